>>> hdl/mbf_pkg.sv
`default_nettype none

package mbf_pkg;

   typedef enum logic [1:0] {
      CMD_READ_COILS    = 2'd0,
      CMD_READ_DISCRETE = 2'd1,
      CMD_READ_HOLDING  = 2'd2,
      CMD_WRITE_SINGLE  = 2'd3
   } command_type;

   localparam logic [7:0] FC_READ_COILS    = 8'h01;
   localparam logic [7:0] FC_READ_DISCRETE = 8'h02;
   localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNIT_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TCP_MODE     = 1'b1;

   localparam logic [7:0]  BYTE_MASK   = 8'hFF;
   localparam logic [15:0] PROTOCOL_ID = 16'h0000;
   // Unit id plus the five-byte PDU.
   localparam logic [15:0] MBAP_LENGTH = 16'd6;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;

   localparam logic [3:0] HEADER_BYTES = 4'd6;
   localparam logic [3:0] RTU_LAST     = 4'd7;
   localparam logic [3:0] TCP_LAST     = 4'd11;
   localparam logic [3:0] CRC_LOW_POS  = 4'd6;

   typedef struct packed {
      logic        tcp;
      logic [7:0]  unit;
      logic [7:0]  fc;
      logic [15:0] addr;
      logic [15:0] opw;
      logic [15:0] tid;
   } desc_type;

   function automatic logic [7:0] fc_of(input command_type cmd);
      logic [7:0] fc;
      case (cmd)
         CMD_READ_COILS:    fc = FC_READ_COILS;
         CMD_READ_DISCRETE: fc = FC_READ_DISCRETE;
         CMD_READ_HOLDING:  fc = FC_READ_HOLDING;
         CMD_WRITE_SINGLE:  fc = FC_WRITE_SINGLE;
         default:           fc = FC_READ_COILS;
      endcase
      return fc;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_prev,
                                            input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_prev ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

>>> hdl/mbf_if.sv
`default_nettype none

interface mbf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] start_address;
   logic [15:0] operand_word;

   modport source(output valid, output command, output start_address,
                  output operand_word, input ready);
   modport sink(input valid, input command, input start_address,
                input operand_word, output ready);
endinterface

interface mbf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source(output valid, output frame_byte, output frame_end, input ready);
   modport sink(input valid, input frame_byte, input frame_end, output ready);
endinterface

`default_nettype wire

>>> hdl/mbf_front.sv
`default_nettype none

module mbf_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   mbf_req_if.sink                                   req_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mbf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [mbf_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  wire logic                                 queue_full,
   output logic                                      push,
   output mbf_pkg::desc_type                         push_desc
);
   import mbf_pkg::*;

   logic [7:0]  unit_ff;
   logic        tcp_ff;
   logic [15:0] tid_ff, tid_in;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;
   assign tid_in         = tid_ff + 16'd1;

   always_comb begin
      push_desc.tcp  = tcp_ff;
      push_desc.unit = unit_ff;
      push_desc.fc   = fc_of(command_type'(req_chan.command));
      push_desc.addr = req_chan.start_address;
      push_desc.opw  = req_chan.operand_word;
      push_desc.tid  = tid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= '0;
         tcp_ff  <= 1'b0;
         tid_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_UNIT_ADDRESS: unit_ff <= csr_write_data & BYTE_MASK;
               CSR_TCP_MODE:     tcp_ff  <= csr_write_data[0];
               default:          ;
            endcase
         end
         // The transaction id only advances for TCP frames.
         if (push && tcp_ff) begin
            tid_ff <= tid_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/mbf_queue.sv
`default_nettype none

module mbf_queue #(
   parameter int Depth = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mbf_pkg::desc_type push_desc,
   input  wire logic              pop,
   output logic                   full,
   output logic                   not_empty,
   output mbf_pkg::desc_type      head
);
   import mbf_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   desc_type                mem [Depth];
   logic [PtrWidth-1:0]     wptr_ff, rptr_ff;
   logic [CountWidth-1:0]   count_ff;

   assign full      = (count_ff == FullCount);
   assign not_empty = (count_ff != '0);
   assign head      = mem[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wptr_ff <= (wptr_ff == LastPtr) ? '0 : wptr_ff + 1'b1;
         end
         if (pop) begin
            rptr_ff <= (rptr_ff == LastPtr) ? '0 : rptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/mbf_back.sv
`default_nettype none

module mbf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              have_item,
   input  wire mbf_pkg::desc_type head,
   output logic                   pop,
   mbf_rsp_if.source              rsp_chan
);
   import mbf_pkg::*;

   logic [3:0]  idx_ff;
   logic [15:0] crc_ff;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_end_ff;

   logic        load;
   logic [3:0]  last_idx;
   logic [3:0]  pdu_pos;
   logic [7:0]  pdu_byte;
   logic [7:0]  next_byte;
   logic [15:0] crc_seed;

   assign last_idx = head.tcp ? TCP_LAST : RTU_LAST;
   assign load     = have_item && (!out_valid_ff || rsp_chan.ready);
   assign pop      = load && (idx_ff == last_idx);
   assign pdu_pos  = head.tcp ? (idx_ff - HEADER_BYTES) : idx_ff;
   assign crc_seed = (idx_ff == '0) ? CRC_INIT : crc_ff;

   always_comb begin
      case (pdu_pos)
         4'd0:    pdu_byte = head.unit;
         4'd1:    pdu_byte = head.fc;
         4'd2:    pdu_byte = head.addr[15:8];
         4'd3:    pdu_byte = head.addr[7:0];
         4'd4:    pdu_byte = head.opw[15:8];
         default: pdu_byte = head.opw[7:0];
      endcase
   end

   always_comb begin
      if (head.tcp) begin
         case (idx_ff)
            4'd0:    next_byte = head.tid[15:8];
            4'd1:    next_byte = head.tid[7:0];
            4'd2:    next_byte = PROTOCOL_ID[15:8];
            4'd3:    next_byte = PROTOCOL_ID[7:0];
            4'd4:    next_byte = MBAP_LENGTH[15:8];
            4'd5:    next_byte = MBAP_LENGTH[7:0];
            default: next_byte = pdu_byte;
         endcase
      end else if (idx_ff < CRC_LOW_POS) begin
         next_byte = pdu_byte;
      end else if (idx_ff == CRC_LOW_POS) begin
         next_byte = crc_ff[7:0];
      end else begin
         next_byte = crc_ff[15:8];
      end
   end

   // The CRC folds in each RTU byte as it is loaded, so it is complete by
   // the time the first CRC byte goes out.
   always_ff @(posedge clock) begin
      if (load && !head.tcp && (idx_ff < CRC_LOW_POS)) begin
         crc_ff <= crc_byte(crc_seed, next_byte);
      end
      if (load) begin
         out_byte_ff <= next_byte;
         out_end_ff  <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff       <= pop ? '0 : idx_ff + 4'd1;
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.frame_byte = out_byte_ff;
   assign rsp_chan.frame_end  = out_end_ff;

endmodule

`default_nettype wire

>>> hdl/modbus_request_framer.sv
`default_nettype none

// Modbus request framer. Each request beat (command, start address, operand)
// becomes one frame, sent one byte per beat on the response channel with
// frame_end set on the last byte: 8 bytes in RTU mode (unit id, PDU, CRC
// low byte first) or 12 bytes in TCP mode (MBAP header with a transaction id
// that advances once per TCP frame, then unit id and PDU). The byte
// serializer emits one byte per cycle while the response channel is ready,
// and a small request queue lets new requests be taken while a frame is
// still going out; the request channel stalls only when that queue is
// full. Write unit_address (index 0) and tcp_mode (index 1) while the
// block is idle.
module modbus_request_framer #(
   parameter int QueueDepth = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   mbf_req_if.sink                                   req_chan,
   mbf_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [mbf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [mbf_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import mbf_pkg::*;

   logic     push, pop, queue_full, queue_not_empty;
   desc_type push_desc, head;

   mbf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_desc        (push_desc)
   );

   mbf_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head)
   );

   mbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .have_item (queue_not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

>>> hdl/mbf_checker.sv
`default_nettype none

module mbf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic       rsp_frame_end
);
   logic       req_beat, rsp_beat;
   logic [3:0] beats_ff;
   logic [4:0] open_ff;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // Bytes seen so far in the current frame, and frames not yet finished.
   always_ff @(posedge clock) begin
      if (reset) begin
         beats_ff <= '0;
         open_ff  <= '0;
      end else begin
         if (rsp_beat) begin
            beats_ff <= rsp_frame_end ? '0 :
                        ((beats_ff == 4'd15) ? beats_ff : beats_ff + 4'd1);
         end
         if (req_beat && !(rsp_beat && rsp_frame_end)) begin
            open_ff <= (open_ff == 5'd31) ? open_ff : open_ff + 5'd1;
         end else if (!req_beat && rsp_beat && rsp_frame_end && open_ff != '0) begin
            open_ff <= open_ff - 5'd1;
         end
      end
   end

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
                                 && $stable(rsp_frame_end))
      else $error("stalled response beat changed");

   a_frame_length: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_frame_end |-> beats_ff == 4'd7 || beats_ff == 4'd11)
      else $error("frame length is neither 8 nor 12 bytes");

   a_frame_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> open_ff != '0)
      else $error("response byte without an accepted request");

endmodule

bind modbus_request_framer mbf_checker u_mbf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_frame_byte (rsp_chan.frame_byte),
   .rsp_frame_end  (rsp_chan.frame_end)
);

`default_nettype wire
